// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands shared by the servo sweep positioner modules. Each
// macro samples on the rising edge of clk and is held off while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define SSP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define SSP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/ssp_pkg.sv =====
// ----------------------------------------------------------------------------
// ssp_pkg
// Shared types, codes and constants of the servo sweep positioner.
// ----------------------------------------------------------------------------
`default_nettype none

package ssp_pkg;

  // Angle limits and reset position
  localparam logic [7:0] FULL_ANGLE   = 8'd180;
  localparam logic [7:0] CENTER_ANGLE = 8'd90;

  // Command codes
  localparam logic [2:0] CMD_TICK   = 3'd0;
  localparam logic [2:0] CMD_SET    = 3'd1;
  localparam logic [2:0] CMD_SWEEP  = 3'd2;
  localparam logic [2:0] CMD_PULSE  = 3'd3;
  localparam logic [2:0] CMD_STOP   = 3'd4;
  localparam logic [2:0] CMD_ATTACH = 3'd5;
  localparam logic [2:0] CMD_DETACH = 3'd6;

  // Servo write kinds
  localparam logic [1:0] KIND_NONE  = 2'd0;
  localparam logic [1:0] KIND_ANGLE = 2'd1;
  localparam logic [1:0] KIND_PULSE = 2'd2;

  // Register map
  localparam int          REG_IDX_W       = 3;
  localparam int          APB_ADDR_W      = 5;
  localparam logic [REG_IDX_W-1:0] REG_MIN_PULSE  = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_MAX_PULSE  = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_LIMITS_EN  = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_WINDOW_LOW = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_WINDOW_HI  = 3'd4;

  // Register reset values
  localparam logic [11:0] MIN_PULSE_RST = 12'd500;
  localparam logic [11:0] MAX_PULSE_RST = 12'd2500;
  localparam logic [7:0]  WIN_LOW_RST   = 8'd0;
  localparam logic [7:0]  WIN_HIGH_RST  = 8'd180;

  // Shared divider: quotient always fits in eight bits
  localparam int DIV_STEPS = 8;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  typedef struct packed {
    logic [2:0]  command;
    logic [7:0]  angle_request;
    logic [15:0] sweep_ms;
    logic [11:0] pulse_request;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  write_kind;
    logic [7:0]  write_angle;
    logic [11:0] write_pulse;
    logic [7:0]  angle_now;
    logic [7:0]  angle_goal;
    logic        moving;
    logic        active;
  } out_item_t;

  typedef struct packed {
    logic [11:0] min_pulse;
    logic [11:0] max_pulse;
    logic        limits_enabled;
    logic [7:0]  window_low;
    logic [7:0]  window_high;
  } cfg_t;

  // Controller to datapath commands
  typedef struct packed {
    logic cap;
    logic prep;
    logic step;
    logic commit;
  } ctl_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic need_div;
  } dp_stat_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PREP,
    ST_DIV,
    ST_DONE
  } st_t;

endpackage

`default_nettype wire

// ===== rtl/ssp_ctrl.sv =====
// ----------------------------------------------------------------------------
// ssp_ctrl
// Sequencer: capture an item, prepare the product, run the divider when the
// item needs it, then commit once the result register is free.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module ssp_ctrl (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                in_valid,
  output logic               in_ready,
  input  wire                out_free,
  input  ssp_pkg::dp_stat_t  stat_i,
  output ssp_pkg::ctl_cmd_t  cmd_o
);
  import ssp_pkg::*;

  localparam logic [DIV_CNT_W-1:0] CNT_LAST = DIV_CNT_W'(DIV_STEPS - 1);

  st_t                  state_r, state_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;

  // State and step counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd_o     = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd_o.cap = 1'b1;
          state_nxt = ST_PREP;
        end
      end
      ST_PREP: begin
        cmd_o.prep = 1'b1;
        cnt_nxt    = '0;
        state_nxt  = stat_i.need_div ? ST_DIV : ST_DONE;
      end
      ST_DIV: begin
        cmd_o.step = 1'b1;
        cnt_nxt    = cnt_r + DIV_CNT_W'(1);
        if (cnt_r == CNT_LAST) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          cmd_o.commit = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  `SSP_ASSERT_NXT(a_cap_then_prep, cmd_o.cap, cmd_o.prep, "capture not followed by prepare")
  `SSP_ASSERT_NXT(a_div_ends, cmd_o.step && cnt_r == CNT_LAST, state_r == ST_DONE,
    "divider overran its step count")

endmodule

`default_nettype wire

// ===== rtl/ssp_dp.sv =====
// ----------------------------------------------------------------------------
// ssp_dp
// Datapath: servo state, angle and pulse clamps, shared multiplier and
// restoring divider, and the per-command state update.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module ssp_dp (
  input  wire                clk,
  input  wire                rst_n,
  input  ssp_pkg::ctl_cmd_t  cmd_i,
  input  ssp_pkg::in_item_t  in_data_i,
  input  ssp_pkg::cfg_t      cfg_i,
  output ssp_pkg::dp_stat_t  stat_o,
  output ssp_pkg::out_item_t res_o
);
  import ssp_pkg::*;

  // Captured item
  in_item_t    item_r;

  // Servo state
  logic [7:0]  cur_r, cur_nxt;
  logic [7:0]  tgt_r, tgt_nxt;
  logic [7:0]  start_r, start_nxt;
  logic [15:0] el_r, el_nxt;
  logic [15:0] dur_r, dur_nxt;
  logic        sweep_r, sweep_nxt;
  logic        att_r, att_nxt;

  // Divider registers
  logic [15:0] rem_r;
  logic [7:0]  quo_r;
  logic [15:0] dvs_r;

  // Combinational terms
  logic [7:0]  a_sat, lo_b, hi_b, lim_a;
  logic [11:0] p_clamp, p_off;
  logic        p_fwd;
  logic [15:0] el_inc;
  logic        tick_div;
  logic        neg;
  logic [7:0]  diff_mag;
  logic [8:0]  sweep_sum;
  logic [7:0]  tick_pos;
  logic [7:0]  mul_a;
  logic [15:0] mul_b;
  logic [23:0] prod;
  logic [16:0] trial, trial_sub;
  logic        trial_ge;
  logic [7:0]  pmap_a;
  logic [1:0]  kind;
  logic [7:0]  wangle;
  logic [11:0] wpulse;

  // Clamp the requested angle to 0..180 and, with limits enabled, to the window
  always_comb begin
    a_sat = (item_r.angle_request > FULL_ANGLE) ? FULL_ANGLE : item_r.angle_request;
    lo_b  = (cfg_i.window_low > FULL_ANGLE) ? FULL_ANGLE : cfg_i.window_low;
    hi_b  = (cfg_i.window_high > FULL_ANGLE) ? FULL_ANGLE : cfg_i.window_high;
    lim_a = a_sat;
    if (cfg_i.limits_enabled) begin
      if (a_sat < lo_b) lim_a = lo_b;
      else if (a_sat > hi_b) lim_a = hi_b;
    end
  end

  // Clamp the requested pulse to the pulse range
  always_comb begin
    p_fwd = cfg_i.min_pulse < cfg_i.max_pulse;
    if (item_r.pulse_request < cfg_i.min_pulse) p_clamp = cfg_i.min_pulse;
    else if (item_r.pulse_request > cfg_i.max_pulse) p_clamp = cfg_i.max_pulse;
    else p_clamp = item_r.pulse_request;
    p_off = p_clamp - cfg_i.min_pulse;
  end

  // Sweep step terms
  always_comb begin
    el_inc    = (el_r != 16'hFFFF) ? el_r + 16'd1 : el_r;
    tick_div  = sweep_r && att_r && (dur_r != '0) && (el_inc < dur_r);
    neg       = tgt_r < start_r;
    diff_mag  = neg ? start_r - tgt_r : tgt_r - start_r;
    sweep_sum = neg ? {1'b0, start_r} - {1'b0, quo_r} : {1'b0, start_r} + {1'b0, quo_r};
    tick_pos  = tick_div ? sweep_sum[7:0] : tgt_r;
  end

  assign stat_o.need_div = ((item_r.command == CMD_TICK) && tick_div) ||
                           ((item_r.command == CMD_PULSE) && p_fwd);

  // Shared multiplier operands
  always_comb begin
    if (item_r.command == CMD_PULSE) begin
      mul_a = FULL_ANGLE;
      mul_b = {4'b0, p_off};
    end else begin
      mul_a = diff_mag;
      mul_b = el_inc;
    end
    prod = 24'(mul_a) * 24'(mul_b);
  end

  // One restoring step
  always_comb begin
    trial     = {rem_r, quo_r[7]};
    trial_sub = trial - {1'b0, dvs_r};
    trial_ge  = trial >= {1'b0, dvs_r};
  end

  // Capture, load product, step the divider
  always_ff @(posedge clk) begin
    if (cmd_i.cap) begin
      item_r <= in_data_i;
    end
    if (cmd_i.prep) begin
      rem_r <= prod[23:8];
      quo_r <= prod[7:0];
      dvs_r <= (item_r.command == CMD_PULSE) ?
               {4'b0, cfg_i.max_pulse - cfg_i.min_pulse} : dur_r;
    end else if (cmd_i.step) begin
      rem_r <= trial_ge ? trial_sub[15:0] : trial[15:0];
      quo_r <= {quo_r[6:0], trial_ge};
    end
  end

  // Mapped angle of the clamped pulse
  always_comb begin
    if (p_fwd) pmap_a = quo_r;
    else if (cfg_i.min_pulse == cfg_i.max_pulse) pmap_a = '0;
    else pmap_a = (p_clamp == cfg_i.min_pulse) ? 8'd0 : FULL_ANGLE;
  end

  // Per-command state update and result
  always_comb begin
    cur_nxt   = cur_r;
    tgt_nxt   = tgt_r;
    start_nxt = start_r;
    el_nxt    = el_r;
    dur_nxt   = dur_r;
    sweep_nxt = sweep_r;
    att_nxt   = att_r;
    kind      = KIND_NONE;
    wangle    = '0;
    wpulse    = '0;
    case (item_r.command) inside
      CMD_TICK: begin
        if (sweep_r) begin
          el_nxt = el_inc;
          if (att_r) begin
            cur_nxt = tick_pos;
            kind    = KIND_ANGLE;
            wangle  = tick_pos;
            if (tick_pos == tgt_r) sweep_nxt = 1'b0;
          end
        end
      end
      CMD_SET, CMD_SWEEP: begin
        if (item_r.command == CMD_SWEEP && item_r.sweep_ms != '0) begin
          tgt_nxt   = lim_a;
          start_nxt = cur_r;
          el_nxt    = '0;
          dur_nxt   = item_r.sweep_ms;
          sweep_nxt = 1'b1;
        end else begin
          sweep_nxt = 1'b0;
          cur_nxt   = lim_a;
          tgt_nxt   = lim_a;
          if (att_r) begin
            kind   = KIND_ANGLE;
            wangle = lim_a;
          end
        end
      end
      CMD_PULSE: begin
        if (att_r) begin
          kind   = KIND_PULSE;
          wpulse = p_clamp;
        end
        cur_nxt   = pmap_a;
        tgt_nxt   = pmap_a;
        sweep_nxt = 1'b0;
      end
      CMD_STOP: begin
        sweep_nxt = 1'b0;
        tgt_nxt   = cur_r;
      end
      CMD_ATTACH: begin
        if (!att_r) begin
          att_nxt = 1'b1;
          kind    = KIND_ANGLE;
          wangle  = cur_r;
        end
      end
      CMD_DETACH: att_nxt = 1'b0;
      default: ;
    endcase

    res_o.write_kind  = kind;
    res_o.write_angle = wangle;
    res_o.write_pulse = wpulse;
    res_o.angle_now   = cur_nxt;
    res_o.angle_goal  = tgt_nxt;
    res_o.moving      = sweep_nxt && (cur_nxt != tgt_nxt);
    res_o.active      = att_nxt;
  end

  // Servo state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r   <= CENTER_ANGLE;
      tgt_r   <= CENTER_ANGLE;
      start_r <= CENTER_ANGLE;
      el_r    <= '0;
      dur_r   <= '0;
      sweep_r <= 1'b0;
      att_r   <= 1'b1;
    end else if (cmd_i.commit) begin
      cur_r   <= cur_nxt;
      tgt_r   <= tgt_nxt;
      start_r <= start_nxt;
      el_r    <= el_nxt;
      dur_r   <= dur_nxt;
      sweep_r <= sweep_nxt;
      att_r   <= att_nxt;
    end
  end

  `SSP_ASSERT_IMP(a_sweep_has_dur, sweep_r, dur_r != '0, "sweep running with zero duration")
  `SSP_ASSERT_IMP(a_angles_in_range, 1'b1, cur_r <= FULL_ANGLE && tgt_r <= FULL_ANGLE,
    "angle state beyond full scale")

endmodule

`default_nettype wire

// ===== rtl/servo_sweep_positioner.sv =====
// ----------------------------------------------------------------------------
// servo_sweep_positioner
// Servo position commander: instant moves, timed linear sweeps, pulse-width
// commands, stop and attach/detach, with an APB register file for the pulse
// range and the angle window.
//
//   Port group     Direction   Handshake            Beat
//   in_*           input       in_valid/in_ready    in_item_t command
//   out_*          output      out_valid/out_ready  out_item_t result
//   APB (p*)       input       psel/penable, pready register write/read
//
// An item passes from acceptance through the prepare and done states to the
// result register, with the shared 8-step restoring divider run in between
// for a tick of an attached sweep before its end, or a pulse command over a
// non-empty range; the next item is taken once the sequencer is back in idle.
// A stalled output holds the sequencer at commit; nothing is dropped.
// Reset is synchronous, active low; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module servo_sweep_positioner (
  input  wire                                clk,
  input  wire                                rst_n,
  // Command channel
  input  wire                                in_valid,
  output logic                               in_ready,
  input  ssp_pkg::in_item_t                  in_data,
  // Result channel
  output logic                               out_valid,
  input  wire                                out_ready,
  output ssp_pkg::out_item_t                 out_data,
  // Register port
  input  wire                                psel,
  input  wire                                penable,
  input  wire                                pwrite,
  input  wire [ssp_pkg::APB_ADDR_W-1:0]      paddr,
  input  wire [31:0]                         pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready
);
  import ssp_pkg::*;

  cfg_t            cfg_r;
  logic            out_valid_r;
  out_item_t       out_data_r;
  logic            out_free;
  logic            wr_en;
  logic [REG_IDX_W-1:0] reg_idx;
  ctl_cmd_t        cmd;
  dp_stat_t        stat;
  out_item_t       res;

  assign pready  = 1'b1;
  assign reg_idx = paddr[APB_ADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite;

  // Register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.min_pulse      <= MIN_PULSE_RST;
      cfg_r.max_pulse      <= MAX_PULSE_RST;
      cfg_r.limits_enabled <= 1'b0;
      cfg_r.window_low     <= WIN_LOW_RST;
      cfg_r.window_high    <= WIN_HIGH_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_MIN_PULSE:  cfg_r.min_pulse      <= pwdata[11:0];
        REG_MAX_PULSE:  cfg_r.max_pulse      <= pwdata[11:0];
        REG_LIMITS_EN:  cfg_r.limits_enabled <= pwdata[0];
        REG_WINDOW_LOW: cfg_r.window_low     <= pwdata[7:0];
        REG_WINDOW_HI:  cfg_r.window_high    <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // Register reads
  always_comb begin
    unique case (reg_idx)
      REG_MIN_PULSE:  prdata = {20'b0, cfg_r.min_pulse};
      REG_MAX_PULSE:  prdata = {20'b0, cfg_r.max_pulse};
      REG_LIMITS_EN:  prdata = {31'b0, cfg_r.limits_enabled};
      REG_WINDOW_LOW: prdata = {24'b0, cfg_r.window_low};
      REG_WINDOW_HI:  prdata = {24'b0, cfg_r.window_high};
      default:        prdata = '0;
    endcase
  end

  assign out_free = !out_valid_r || out_ready;

  ssp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_free (out_free),
    .stat_i   (stat),
    .cmd_o    (cmd)
  );

  ssp_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_i     (cmd),
    .in_data_i (in_data),
    .cfg_i     (cfg_r),
    .stat_o    (stat),
    .res_o     (res)
  );

  // Output register: load on commit, drop on take
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `SSP_ASSERT_NXT(a_one_in_flight, in_valid && in_ready, !in_ready,
    "second item taken while one is in flight")
  `SSP_ASSERT_NXT(a_commit_shows, cmd.commit, out_valid, "committed result not presented")
  `SSP_ASSERT_IMP(a_no_overwrite, cmd.commit, !out_valid_r || out_ready,
    "result register overwritten while stalled")

endmodule

`default_nettype wire
